// File: hw/rtl/wls_pkg.sv
// ----------------------------------------------------------------------------
// wls_pkg
// types and constants for the windowed latency statistics block
// ----------------------------------------------------------------------------
package wls_pkg;

  typedef struct packed {
    logic [3:0]  scope_slot;
    logic [31:0] duration_ticks;
    logic [63:0] frame_number;
    logic [63:0] start_tick;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  result_scope;
    logic [31:0] last_duration;
    logic [31:0] mean_duration;
    logic [31:0] peak_duration;
    logic [31:0] p95_duration;
    logic [63:0] result_frame;
    logic [63:0] result_start_tick;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDOLD,
    ST_WAITOLD,
    ST_WRITE,
    ST_SCAN,
    ST_DIV,
    ST_SEL,
    ST_SELNEXT,
    ST_DONE
  } state_t;

  localparam int unsigned SLOT_W = 4;
  localparam int unsigned DUR_W  = 32;

endpackage

// File: hw/rtl/windowed_latency_statistics.sv
// ----------------------------------------------------------------------------
// windowed_latency_statistics
// per-scope sliding window of durations: latest, floor mean, peak and p95
// ----------------------------------------------------------------------------
// latency per word runs from acceptance through the oldest read, write, peak
// scan, divide and p95 pick, plus any time that out_stall holds the result.
// the p95 pick reads each candidate, then counts how many window entries are
// smaller or equal, one memory read a cycle through the single read port.
// one word at a time; in_stall is high from acceptance until the result goes.
// rst clears fill, oldest position and sum per scope; the window memory is not.
module windowed_latency_statistics #(
  parameter int unsigned SCOPE_COUNT = 16,
  parameter int unsigned WINDOW_LEN  = 120
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wls_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wls_pkg::out_word_t   out_data
);

  localparam int unsigned SW   = (SCOPE_COUNT > 1) ? $clog2(SCOPE_COUNT) : 1;
  localparam int unsigned PW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FW   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUMW = wls_pkg::DUR_W + FW;
  localparam int unsigned DEPTH = SCOPE_COUNT * WINDOW_LEN;
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW   = FW + 7;
  localparam int unsigned DCW  = $clog2(wls_pkg::DUR_W + 1);

  wls_pkg::state_t state, state_next;

  logic [wls_pkg::DUR_W-1:0] mem [DEPTH];
  logic [wls_pkg::DUR_W-1:0] rdata;
  logic [AW-1:0]             raddr;
  logic                      rd_en;

  logic [FW-1:0]   fill [SCOPE_COUNT];
  logic [PW-1:0]   oldest [SCOPE_COUNT];
  logic [SUMW-1:0] sum [SCOPE_COUNT];

  wls_pkg::in_word_t  item;
  logic [SW-1:0]      slot;
  logic [AW-1:0]      base;
  logic [FW-1:0]      n;
  logic [FW-1:0]      k;
  logic [PW-1:0]      old;
  logic [SUMW-1:0]    tot;
  logic [FW-1:0]      i;
  logic [FW:0]        j;
  logic [wls_pkg::DUR_W-1:0] peak;
  logic [wls_pkg::DUR_W-1:0] cand;
  logic [wls_pkg::DUR_W-1:0] best;
  logic                      best_ok;
  logic [FW-1:0]             cnt;
  logic [SUMW-1:0]           rem;
  logic [wls_pkg::DUR_W-1:0] quo;
  logic [DCW-1:0]            dstep;

  logic [SW-1:0] in_slot;
  logic [SUMW:0] rem_sh;
  logic [KW-1:0] k_num;
  logic [KW-1:0] k_div;
  logic [FW-1:0] k_calc;

  // slot fold, one constant per possible slot code
  always_comb begin
    in_slot = '0;
    for (int v = 0; v < (1 << wls_pkg::SLOT_W); v++) begin
      if (in_data.scope_slot == 4'(v)) in_slot = SW'(v % SCOPE_COUNT);
    end
  end

  // ceil(95n/100)-1 by reciprocal: x/100 = x*167773 >> 24 for x < 2^17
  always_comb begin
    k_num  = KW'(95 * 32'(n) + 99);
    k_div  = KW'((64'(k_num) * 64'd167773) >> 24);
    k_calc = (k_div == '0) ? '0 : FW'(k_div - KW'(1));
    if (k_calc > n - FW'(1)) k_calc = n - FW'(1);
  end

  function automatic logic [PW-1:0] ring(input logic [PW-1:0] a, input logic [FW-1:0] b);
    logic [FW:0] s;
    s = (FW+1)'(a) + (FW+1)'(b);
    if (s >= (FW+1)'(WINDOW_LEN)) s = s - (FW+1)'(WINDOW_LEN);
    return PW'(s);
  endfunction

  assign rem_sh = {rem, quo[wls_pkg::DUR_W-1]};

  always_comb begin
    state_next = state;
    case (state)
      wls_pkg::ST_IDLE:     if (in_valid) state_next = wls_pkg::ST_RDOLD;
      wls_pkg::ST_RDOLD:    state_next = wls_pkg::ST_WAITOLD;
      wls_pkg::ST_WAITOLD:  state_next = wls_pkg::ST_WRITE;
      wls_pkg::ST_WRITE:    state_next = wls_pkg::ST_SCAN;
      wls_pkg::ST_SCAN:     if (i == n) state_next = wls_pkg::ST_DIV;
      wls_pkg::ST_DIV:      if (dstep == DCW'(wls_pkg::DUR_W)) state_next = wls_pkg::ST_SEL;
      wls_pkg::ST_SEL:      if (j == (FW+1)'(n) + (FW+1)'(1)) state_next = wls_pkg::ST_SELNEXT;
      wls_pkg::ST_SELNEXT:  if (i == n - FW'(1)) state_next = wls_pkg::ST_DONE;
                            else state_next = wls_pkg::ST_SEL;
      wls_pkg::ST_DONE:     if (!out_stall) state_next = wls_pkg::ST_IDLE;
      default:              state_next = wls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != wls_pkg::ST_IDLE);
    out_valid = (state == wls_pkg::ST_DONE);
    out_data.result_scope      = 4'(slot);
    out_data.last_duration     = item.duration_ticks;
    out_data.mean_duration     = quo;
    out_data.peak_duration     = peak;
    out_data.p95_duration      = best;
    out_data.result_frame      = item.frame_number;
    out_data.result_start_tick = item.start_tick;
  end

  // read address: oldest slot for removal, ring walk otherwise
  always_comb begin
    rd_en = 1'b0;
    raddr = base + AW'(old);
    case (state)
      wls_pkg::ST_RDOLD: rd_en = 1'b1;
      wls_pkg::ST_SCAN: begin
        rd_en = (i < n);
        raddr = base + AW'(ring(old, i));
      end
      wls_pkg::ST_SEL: begin
        // candidate first, then the whole window
        rd_en = (j <= (FW+1)'(n));
        raddr = base + AW'(ring(old, (j == '0) ? i : FW'(j - (FW+1)'(1))));
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[raddr];
    if (state == wls_pkg::ST_WRITE) mem[base + AW'(ring(old, (fill[slot] < FW'(WINDOW_LEN))
        ? fill[slot] : FW'(0)))] <= item.duration_ticks;
  end

  // scan pipeline: read issued at i, data valid in the following cycle
  logic          scan_v;
  logic          sel_v;
  logic [FW-1:0] sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wls_pkg::ST_IDLE;
      for (int s = 0; s < SCOPE_COUNT; s++) begin
        fill[s]   <= '0;
        oldest[s] <= '0;
        sum[s]    <= '0;
      end
      scan_v <= 1'b0;
      sel_v  <= 1'b0;
    end else begin
      state  <= state_next;
      scan_v <= (state == wls_pkg::ST_SCAN) && (i < n);
      sel_v  <= (state == wls_pkg::ST_SEL) && (j <= (FW+1)'(n));
      if (state == wls_pkg::ST_WRITE) begin
        if (fill[slot] < FW'(WINDOW_LEN)) begin
          fill[slot] <= fill[slot] + FW'(1);
          sum[slot]  <= sum[slot] + SUMW'(item.duration_ticks);
        end else begin
          oldest[slot] <= ring(old, FW'(1));
          sum[slot]    <= sum[slot] - SUMW'(rdata) + SUMW'(item.duration_ticks);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wls_pkg::ST_IDLE: if (in_valid) begin
        item <= in_data;
        slot <= in_slot;
        base <= AW'(32'(in_slot) * WINDOW_LEN);
        old  <= oldest[in_slot];
      end
      wls_pkg::ST_WRITE: begin
        if (fill[slot] < FW'(WINDOW_LEN)) begin
          n   <= fill[slot] + FW'(1);
          tot <= sum[slot] + SUMW'(item.duration_ticks);
        end else begin
          n   <= fill[slot];
          old <= ring(old, FW'(1));
          tot <= sum[slot] - SUMW'(rdata) + SUMW'(item.duration_ticks);
        end
        i    <= '0;
        peak <= '0;
      end
      wls_pkg::ST_SCAN: begin
        if (i < n) i <= i + FW'(1);
        if (scan_v && rdata > peak) peak <= rdata;
        if (i == n) begin
          rem   <= SUMW'(tot >> wls_pkg::DUR_W);
          quo   <= tot[wls_pkg::DUR_W-1:0];
          dstep <= '0;
          k     <= k_calc;
        end
      end
      wls_pkg::ST_DIV: begin
        // restoring divide, one quotient bit a cycle; tot fits SUMW bits
        if (dstep != DCW'(wls_pkg::DUR_W)) begin
          if (rem_sh >= (SUMW+1)'(n)) begin
            rem <= SUMW'(rem_sh - (SUMW+1)'(n));
            quo <= {quo[wls_pkg::DUR_W-2:0], 1'b1};
          end else begin
            rem <= SUMW'(rem_sh);
            quo <= {quo[wls_pkg::DUR_W-2:0], 1'b0};
          end
          dstep <= dstep + DCW'(1);
        end
        if (dstep == DCW'(wls_pkg::DUR_W)) begin
          i       <= '0;
          j       <= '0;
          best_ok <= 1'b0;
          best    <= '0;
          cnt     <= '0;
          sel_last <= '0;
        end
      end
      wls_pkg::ST_SEL: begin
        if (j <= (FW+1)'(n)) j <= j + (FW+1)'(1);
        if (sel_v) begin
          if (sel_last == '0) cand <= rdata;
          else if (rdata <= cand) cnt <= cnt + FW'(1);
          sel_last <= sel_last + FW'(1);
        end
      end
      wls_pkg::ST_SELNEXT: begin
        // smallest value whose count of <= exceeds k is sorted[k]
        if (cnt > k && (!best_ok || cand < best)) begin
          best    <= cand;
          best_ok <= 1'b1;
        end
        i        <= i + FW'(1);
        j        <= '0;
        cnt      <= '0;
        sel_last <= '0;
      end
      default: begin
      end
    endcase
  end

  // scope count is a power of two or the fold keeps the slot in range
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    state != wls_pkg::ST_IDLE |-> 32'(slot) < SCOPE_COUNT) else $error("slot out of range");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == wls_pkg::ST_DIV |-> (n != '0 && 32'(n) <= WINDOW_LEN)) else $error("bad fill");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule
